>>> src/malt_pkg.sv
`timescale 1ns / 1ps
package malt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    // radix-8 gather levels from the cell row down to one record
    localparam int GATHER_LVLS = (IDX_W + 2) / 3;
    localparam int GCNT_W      = $clog2(GATHER_LVLS + 1);
    // widest registered gather level, the first one above the cell row
    localparam int GATHER_W    = (TABLE_DEPTH + 7) >> 3;

    // field widths
    localparam int MAC_W   = 48;
    localparam int MASK_W  = 8;
    localparam int PORT_W  = 3;
    localparam int ETYPE_W = 16;
    localparam int ACT_W   = 3;
    localparam int OIDX_W  = 6;
    localparam int CNT_W   = 32;

    // constants
    localparam logic [ETYPE_W-1:0] ARP_TYPE    = 16'h0806;
    localparam logic [MAC_W-1:0]   BCAST_MAC   = 48'hffff_ffff_ffff;
    localparam logic [MAC_W-1:0]   OWN_MAC_RST = 48'h4e00_0000_f050;

    // learn action codes
    localparam logic [ACT_W-1:0] LA_NONE  = 3'd0;
    localparam logic [ACT_W-1:0] LA_KNOWN = 3'd1;
    localparam logic [ACT_W-1:0] LA_ADDED = 3'd2;
    localparam logic [ACT_W-1:0] LA_NEW   = 3'd3;
    localparam logic [ACT_W-1:0] LA_FULL  = 3'd4;

    // command broadcast to every cell
    typedef struct packed {
        logic               cmp;
        logic               set_port;
        logic               append;
        logic [MAC_W-1:0]   key;
        logic [MASK_W-1:0]  pbit;
    } cell_cmd_t;

    // per-cell search record, zero unless the cell has something to say
    typedef struct packed {
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic [MASK_W-1:0]  mask;
        logic [MAC_W-1:0]   mac;
        logic               free;
        logic [IDX_W-1:0]   free_idx;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // node count of a gather level, level zero being the cell row
    function automatic int nodes_at(input int lvl);
        return (TABLE_DEPTH + (1 << (3 * lvl)) - 1) >> (3 * lvl);
    endfunction

endpackage

>>> src/malt_in_if.sv
`timescale 1ns / 1ps
interface malt_in_if;
    import malt_pkg::*;

    logic                valid;
    logic                ready;
    logic                rx_error;
    logic [PORT_W-1:0]   ingress_port;
    logic [MAC_W-1:0]    dest_mac;
    logic [MAC_W-1:0]    src_mac;
    logic [ETYPE_W-1:0]  ether_type;

    modport source (
        output valid, rx_error, ingress_port, dest_mac, src_mac, ether_type,
        input  ready
    );

    modport sink (
        input  valid, rx_error, ingress_port, dest_mac, src_mac, ether_type,
        output ready
    );
endinterface

>>> src/malt_out_if.sv
`timescale 1ns / 1ps
interface malt_out_if;
    import malt_pkg::*;

    logic               valid;
    logic               ready;
    logic               frame_ok;
    logic               is_arp;
    logic [ACT_W-1:0]   learn_action;
    logic [OIDX_W-1:0]  entry_index;
    logic [MASK_W-1:0]  entry_port_mask;
    logic [MAC_W-1:0]   entry_mac;
    logic               table_write;
    logic               clear_hit;
    logic               to_cpu;
    logic [CNT_W-1:0]   cpu_frame_total;

    modport source (
        output valid, frame_ok, is_arp, learn_action, entry_index, entry_port_mask,
               entry_mac, table_write, clear_hit, to_cpu, cpu_frame_total,
        input  ready
    );

    modport sink (
        input  valid, frame_ok, is_arp, learn_action, entry_index, entry_port_mask,
               entry_mac, table_write, clear_hit, to_cpu, cpu_frame_total,
        output ready
    );
endinterface

>>> src/mac_address_learning_table_unit.sv
`timescale 1ns / 1ps
// MAC learning table: one frame header per item. Error frames pass through as
// dropped. ARP frames look up their source MAC among entries 1 and up, which sit
// in a row of cells that compare in parallel; each cell registers its hit and a
// first-free mark taken from its neighbor's occupancy, and a registered radix-8
// or-tree (GATHER_LVLS levels) merges the cell records. An item passes through a
// compare state, the gather levels and an update state in which its result is
// loaded once the output is free; the next item is accepted in the cycle the result
// is loaded and not before, so items never overlap in the table. Frames to the
// broadcast address or to own_mac are counted as CPU frames.
module mac_address_learning_table_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    malt_in_if.sink                      in_ch,
    malt_out_if.source                   out_ch,
    input  logic                         cfg_we,
    input  logic [malt_pkg::MAC_W-1:0]   cfg_data
);
    import malt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CMP    = 4'b0010,
        S_GATHER = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [GCNT_W-1:0]    gcnt_reg, gcnt_next;
    logic [MAC_W-1:0]     own_mac_reg;
    logic [CNT_W-1:0]     cpu_cnt_reg, cpu_cnt_next;

    // captured item
    logic                 err_reg;
    logic [PORT_W-1:0]    port_reg;
    logic [MAC_W-1:0]     dst_reg;
    logic [MAC_W-1:0]     src_reg;
    logic [ETYPE_W-1:0]   etype_reg;

    // result register
    logic                 ovalid_reg, ovalid_next;
    logic                 ok_reg, ok_next;
    logic                 arp_reg, arp_next;
    logic [ACT_W-1:0]     act_reg, act_next;
    logic [OIDX_W-1:0]    idx_reg, idx_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;
    logic [MAC_W-1:0]     mac_reg, mac_next;
    logic                 wr_reg, wr_next;
    logic                 clr_reg, clr_next;
    logic                 cpu_reg, cpu_next;

    logic                 in_acc;
    logic                 fire;
    logic [MASK_W-1:0]    pbit;
    cell_cmd_t            cmd;
    rec_t                 recs [TABLE_DEPTH];
    rec_t                 found;
    logic [TABLE_DEPTH-1:0] occ_vec;
    logic [TABLE_DEPTH-1:0] hit_vec;

    // handshake
    assign fire        = (state_reg == S_UPDATE) && (!ovalid_reg || out_ch.ready);
    assign in_ch.ready = (state_reg == S_IDLE) || fire;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign pbit        = MASK_W'(1) << port_reg;

    // cell commands
    always_comb
    begin
        cmd          = '0;
        cmd.cmp      = (state_reg == S_CMP);
        cmd.key      = src_reg;
        cmd.pbit     = pbit;
        cmd.set_port = fire && !err_reg && (etype_reg == ARP_TYPE) && found.hit;
        cmd.append   = fire && !err_reg && (etype_reg == ARP_TYPE) && !found.hit
                       && found.free;
    end

    // entry zero holds own_mac and is never searched
    assign occ_vec[0] = 1'b1;
    assign hit_vec[0] = 1'b0;
    assign recs[0]    = '0;

    // cell row, occupancy handed down the chain
    for (genvar i = 1; i < TABLE_DEPTH; i++)
    begin : g_cell
        malt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .prev_occ (occ_vec[i - 1]),
            .cmd      (cmd),
            .occ      (occ_vec[i]),
            .rec      (recs[i])
        );
        assign hit_vec[i] = recs[i].hit;
    end

    malt_gather u_gather (
        .clk     (clk),
        .rec_in  (recs),
        .rec_out (found)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        gcnt_next  = gcnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_GATHER;
                gcnt_next  = '0;
            end
            S_GATHER:
            begin
                gcnt_next = gcnt_reg + GCNT_W'(1);
                if (gcnt_reg == GCNT_W'(GATHER_LVLS - 1))
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (fire)
                    state_next = in_acc ? S_CMP : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result of the current item
    always_comb
    begin
        ok_next      = 1'b0;
        arp_next     = 1'b0;
        act_next     = LA_NONE;
        idx_next     = '0;
        mask_next    = '0;
        mac_next     = '0;
        wr_next      = 1'b0;
        clr_next     = 1'b0;
        cpu_next     = 1'b0;
        cpu_cnt_next = cpu_cnt_reg;
        if (!err_reg)
        begin
            ok_next  = 1'b1;
            arp_next = (etype_reg == ARP_TYPE);
            cpu_next = (dst_reg == BCAST_MAC) || (dst_reg == own_mac_reg);
            if (cpu_next)
                cpu_cnt_next = cpu_cnt_reg + CNT_W'(1);
            if (arp_next)
            begin
                if (found.hit)
                begin
                    idx_next = OIDX_W'(found.hit_idx);
                    mac_next = found.mac;
                    if ((found.mask & pbit) != '0)
                    begin
                        act_next  = LA_KNOWN;
                        mask_next = found.mask;
                    end
                    else
                    begin
                        act_next  = LA_ADDED;
                        mask_next = found.mask | pbit;
                        wr_next   = 1'b1;
                        clr_next  = 1'b1;
                    end
                end
                else if (found.free)
                begin
                    act_next  = LA_NEW;
                    idx_next  = OIDX_W'(found.free_idx);
                    mask_next = pbit;
                    mac_next  = src_reg;
                    wr_next   = 1'b1;
                end
                else
                begin
                    act_next = LA_FULL;
                end
            end
        end
    end

    // output valid
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_ch.ready)
            ovalid_next = 1'b0;
        if (fire)
            ovalid_next = 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            gcnt_reg    <= '0;
            own_mac_reg <= OWN_MAC_RST;
            cpu_cnt_reg <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            gcnt_reg   <= gcnt_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
                own_mac_reg <= cfg_data;
            if (fire)
                cpu_cnt_reg <= cpu_cnt_next;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            err_reg   <= in_ch.rx_error;
            port_reg  <= in_ch.ingress_port;
            dst_reg   <= in_ch.dest_mac;
            src_reg   <= in_ch.src_mac;
            etype_reg <= in_ch.ether_type;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg   <= ok_next;
            arp_reg  <= arp_next;
            act_reg  <= act_next;
            idx_reg  <= idx_next;
            mask_reg <= mask_next;
            mac_reg  <= mac_next;
            wr_reg   <= wr_next;
            clr_reg  <= clr_next;
            cpu_reg  <= cpu_next;
        end
    end

    assign out_ch.valid           = ovalid_reg;
    assign out_ch.frame_ok        = ok_reg;
    assign out_ch.is_arp          = arp_reg;
    assign out_ch.learn_action    = act_reg;
    assign out_ch.entry_index     = idx_reg;
    assign out_ch.entry_port_mask = mask_reg;
    assign out_ch.entry_mac       = mac_reg;
    assign out_ch.table_write     = wr_reg;
    assign out_ch.clear_hit       = clr_reg;
    assign out_ch.to_cpu          = cpu_reg;
    assign out_ch.cpu_frame_total = cpu_cnt_reg;

    // entries are unique, so no two cells may hit on the same key
    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GATHER) |-> $onehot0(hit_vec))
        else $error("more than one cell matched the source mac");

    // occupied cells form an unbroken run from the bottom of the row
    a_occ_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec >> 1) & ~occ_vec) == '0)
        else $error("gap in occupied cells");

    // a table write comes only with a port add or a new entry
    a_wr_act: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.table_write)
            |-> (out_ch.learn_action == LA_ADDED || out_ch.learn_action == LA_NEW))
        else $error("table write without learning");

    // a dropped frame leaves the cpu count unchanged
    a_err_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && err_reg) |=> $stable(cpu_cnt_reg))
        else $error("error frame changed the cpu count");

endmodule

>>> src/malt_cell.sv
`timescale 1ns / 1ps
module malt_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [malt_pkg::IDX_W-1:0]   cell_idx,
    input  logic                         prev_occ,
    input  malt_pkg::cell_cmd_t          cmd,
    output logic                         occ,
    output malt_pkg::rec_t               rec
);
    import malt_pkg::*;

    logic               occ_reg, occ_next;
    logic               hit_reg, hit_next;
    logic               free_reg, free_next;
    logic [MAC_W-1:0]   mac_reg;
    logic [MASK_W-1:0]  mask_reg;

    // match and first-free flags, taken on the compare cycle
    always_comb
    begin
        hit_next  = hit_reg;
        free_next = free_reg;
        occ_next  = occ_reg;
        if (cmd.cmp)
        begin
            hit_next  = occ_reg && (mac_reg == cmd.key);
            free_next = prev_occ && !occ_reg;
        end
        if (cmd.append && free_reg)
        begin
            occ_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
    end

    // entry contents: load on append, merge port bit on hit update
    always_ff @(posedge clk)
    begin
        if (cmd.append && free_reg)
        begin
            mac_reg  <= cmd.key;
            mask_reg <= cmd.pbit;
        end
        else if (cmd.set_port && hit_reg)
        begin
            mask_reg <= mask_reg | cmd.pbit;
        end
    end

    // record toward the gather tree
    always_comb
    begin
        rec          = '0;
        rec.hit      = hit_reg;
        rec.free     = free_reg;
        if (hit_reg)
        begin
            rec.hit_idx = cell_idx;
            rec.mask    = mask_reg;
            rec.mac     = mac_reg;
        end
        if (free_reg)
        begin
            rec.free_idx = cell_idx;
        end
    end

    assign occ = occ_reg;

endmodule

>>> src/malt_gather.sv
`timescale 1ns / 1ps
module malt_gather (
    input  logic             clk,
    input  malt_pkg::rec_t   rec_in [malt_pkg::TABLE_DEPTH],
    output malt_pkg::rec_t   rec_out
);
    import malt_pkg::*;

    // entries are unique, so at most one cell reports a hit and one a free slot;
    // a plain or-tree merges the records, one registered radix-8 level per cycle
    logic [REC_W-1:0] tree_reg [GATHER_LVLS][GATHER_W];

    always_ff @(posedge clk)
    begin
        logic [REC_W-1:0] acc;
        for (int k = 0; k < GATHER_LVLS; k++)
        begin
            for (int j = 0; j < GATHER_W; j++)
            begin
                if (j < nodes_at(k + 1))
                begin
                    acc = '0;
                    for (int c = 0; c < 8; c++)
                    begin
                        if (j * 8 + c < nodes_at(k))
                        begin
                            if (k == 0)
                                acc = acc | rec_in[j * 8 + c];
                            else
                                acc = acc | tree_reg[k - 1][j * 8 + c];
                        end
                    end
                    tree_reg[k][j] <= acc;
                end
            end
        end
    end

    assign rec_out = rec_t'(tree_reg[GATHER_LVLS - 1][0]);

endmodule

>>> test/tb_mac_address_learning_table_unit.sv
`timescale 1ns / 1ps
module tb_mac_address_learning_table_unit;
    import malt_pkg::*;

    localparam int ITEMS_PER_PHASE = 430;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 8;

    // one frame header as driven into the block
    typedef struct packed {
        logic               err;
        logic [PORT_W-1:0]  port;
        logic [MAC_W-1:0]   dst;
        logic [MAC_W-1:0]   src;
        logic [ETYPE_W-1:0] et;
    } frame_t;

    // one learning verdict as produced by the block
    typedef struct packed {
        logic               ok;
        logic               arp;
        logic [ACT_W-1:0]   act;
        logic [OIDX_W-1:0]  idx;
        logic [MASK_W-1:0]  mask;
        logic [MAC_W-1:0]   mac;
        logic               wr;
        logic               clr;
        logic               cpu;
        logic [CNT_W-1:0]   total;
    } verdict_t;

    // directed stimulus row, with a hand-written verdict where typed is set
    typedef struct packed {
        frame_t   frm;
        logic     typed;
        verdict_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [MAC_W-1:0] cfg_data;

    malt_in_if  frame_ch ();
    malt_out_if verdict_ch ();

    mac_address_learning_table_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (frame_ch),
        .out_ch   (verdict_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // shadow of the learning table
    logic [MAC_W-1:0]  own_mac_q;
    logic [MAC_W-1:0]  mac_tbl [TABLE_DEPTH];
    logic [MASK_W-1:0] mask_tbl [TABLE_DEPTH];
    int unsigned       used_entries;
    logic [CNT_W-1:0]  cpu_cnt;

    verdict_t verdict_q[$];
    dir_row_t dir_rows[$];

    int err_count = 0;
    int frames_sent;
    int verdicts_checked = 0;
    int full_seen;
    int src_idle;
    int snk_idle;
    int idle_cycles = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // learning step: updates the shadow table and returns the verdict
    function automatic verdict_t learn_frame(input frame_t f);
        verdict_t          v;
        logic [MASK_W-1:0] pbit;
        logic              hit;
        int unsigned       hit_at;
        v = '0;
        pbit = 8'(1) << f.port;
        hit = 1'b0;
        hit_at = 0;
        if (!f.err)
        begin
            v.ok  = 1'b1;
            v.arp = (f.et == ARP_TYPE);
            if (v.arp)
            begin
                // lowest matching entry above the station entry wins
                for (int i = 1; i < int'(used_entries); i++)
                begin
                    if (!hit && mac_tbl[i] == f.src)
                    begin
                        hit = 1'b1;
                        hit_at = i;
                    end
                end
                if (hit)
                begin
                    if ((mask_tbl[hit_at] & pbit) != '0)
                        v.act = LA_KNOWN;
                    else
                    begin
                        mask_tbl[hit_at] = mask_tbl[hit_at] | pbit;
                        v.act = LA_ADDED;
                        v.wr  = 1'b1;
                        v.clr = 1'b1;
                    end
                    v.idx  = OIDX_W'(hit_at);
                    v.mask = mask_tbl[hit_at];
                    v.mac  = mac_tbl[hit_at];
                end
                else if (used_entries < TABLE_DEPTH)
                begin
                    mac_tbl[used_entries]  = f.src;
                    mask_tbl[used_entries] = pbit;
                    v.act  = LA_NEW;
                    v.idx  = OIDX_W'(used_entries);
                    v.mask = pbit;
                    v.mac  = f.src;
                    v.wr   = 1'b1;
                    used_entries++;
                end
                else
                begin
                    v.act = LA_FULL;
                    full_seen++;
                end
            end
            v.cpu = (f.dst == BCAST_MAC) || (f.dst == own_mac_q);
            if (v.cpu)
                cpu_cnt = cpu_cnt + CNT_W'(1);
        end
        v.total = cpu_cnt;
        return v;
    endfunction

    // random header, mostly arp with sources drawn from the learned set
    function automatic frame_t random_frame();
        frame_t      f;
        logic [63:0] r_src;
        logic [63:0] r_dst;
        int          pick;
        r_src = {$urandom(), $urandom()};
        r_dst = {$urandom(), $urandom()};
        f.err  = ($urandom_range(15) == 0);
        f.port = PORT_W'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 75)
            f.et = ARP_TYPE;
        else if (pick < 82)
            f.et = ARP_TYPE ^ (16'd1 << $urandom_range(15));
        else
            f.et = ETYPE_W'($urandom_range(16'hffff));
        // source address
        pick = $urandom_range(99);
        if (pick < 55 && used_entries > 1)
            f.src = mac_tbl[$urandom_range(used_entries - 1, 1)];
        else if (pick < 85)
            f.src = r_src[MAC_W-1:0];
        else
        begin
            case ($urandom_range(3))
                0: f.src = own_mac_q;
                1: f.src = '0;
                2: f.src = BCAST_MAC;
                default:
                begin
                    if (used_entries > 1)
                        f.src = mac_tbl[$urandom_range(used_entries - 1, 1)]
                                ^ (48'd1 << $urandom_range(47));
                    else
                        f.src = r_src[MAC_W-1:0];
                end
            endcase
        end
        // destination address
        pick = $urandom_range(99);
        if (pick < 25)
            f.dst = BCAST_MAC;
        else if (pick < 45)
            f.dst = own_mac_q;
        else if (pick < 60)
            f.dst = own_mac_q ^ (48'd1 << $urandom_range(47));
        else
            f.dst = r_dst[MAC_W-1:0];
        return f;
    endfunction

    task automatic add_row(input frame_t f, input logic typed, input verdict_t want);
        dir_rows.push_back('{f, typed, want});
    endtask

    // drive one header and wait for it to be taken, starts and ends on a falling edge
    task automatic send_frame(input frame_t f, input logic typed, input verdict_t want);
        verdict_t v;
        while ($urandom_range(99) < src_idle)
        begin
            frame_ch.valid <= 1'b0;
            @(negedge clk);
        end
        frame_ch.valid        <= 1'b1;
        frame_ch.rx_error     <= f.err;
        frame_ch.ingress_port <= f.port;
        frame_ch.dest_mac     <= f.dst;
        frame_ch.src_mac      <= f.src;
        frame_ch.ether_type   <= f.et;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        v = learn_frame(f);
        verdict_q.push_back(typed ? want : v);
        frames_sent++;
        @(negedge clk);
    endtask

    // let every outstanding verdict come back, then settle
    task automatic drain();
        frame_ch.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_own_mac(input logic [MAC_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        own_mac_q = value;
    endtask

    // result side backpressure
    always @(negedge clk)
    begin
        verdict_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle);
    end

    // result checker
    always @(posedge clk)
    begin
        verdict_t w;
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            if (verdict_q.size() == 0)
                report_error("verdict with no frame pending");
            else
            begin
                w = verdict_q.pop_front();
                check_field("frame_ok", 64'(verdict_ch.frame_ok), 64'(w.ok));
                check_field("is_arp", 64'(verdict_ch.is_arp), 64'(w.arp));
                check_field("learn_action", 64'(verdict_ch.learn_action), 64'(w.act));
                check_field("entry_index", 64'(verdict_ch.entry_index), 64'(w.idx));
                check_field("entry_port_mask", 64'(verdict_ch.entry_port_mask),
                            64'(w.mask));
                check_field("entry_mac", 64'(verdict_ch.entry_mac), 64'(w.mac));
                check_field("table_write", 64'(verdict_ch.table_write), 64'(w.wr));
                check_field("clear_hit", 64'(verdict_ch.clear_hit), 64'(w.clr));
                check_field("to_cpu", 64'(verdict_ch.to_cpu), 64'(w.cpu));
                check_field("cpu_frame_total", 64'(verdict_ch.cpu_frame_total),
                            64'(w.total));
                verdicts_checked++;
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((frame_ch.valid && frame_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d cycles with no item accepted", idle_cycles);
                $display("mac_address_learning_table_unit test failed");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        frame_ch.valid        = 1'b0;
        frame_ch.rx_error     = 1'b0;
        frame_ch.ingress_port = '0;
        frame_ch.dest_mac     = '0;
        frame_ch.src_mac      = '0;
        frame_ch.ether_type   = '0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        frames_sent   = 0;
        full_seen     = 0;
        src_idle      = 15;
        snk_idle      = 66;

        // shadow reset state
        own_mac_q    = OWN_MAC_RST;
        mac_tbl[0]   = OWN_MAC_RST;
        mask_tbl[0]  = 8'h01;
        used_entries = 1;
        cpu_cnt      = '0;

        // directed rows: error drop, cpu counting, learn extremes, near-arp types
        add_row('{1'b1, 3'd7, BCAST_MAC, BCAST_MAC, ARP_TYPE}, 1'b1,
                '{1'b0, 1'b0, LA_NONE, 6'd0, 8'h00, 48'h0, 1'b0, 1'b0, 1'b0, 32'd0});
        add_row('{1'b0, 3'd0, BCAST_MAC, 48'h0, 16'h0000}, 1'b1,
                '{1'b1, 1'b0, LA_NONE, 6'd0, 8'h00, 48'h0, 1'b0, 1'b0, 1'b1, 32'd1});
        add_row('{1'b0, 3'd3, OWN_MAC_RST, 48'h1234_5678_9abc, 16'hffff}, 1'b1,
                '{1'b1, 1'b0, LA_NONE, 6'd0, 8'h00, 48'h0, 1'b0, 1'b0, 1'b1, 32'd2});
        add_row('{1'b0, 3'd0, 48'h0, 48'h0, ARP_TYPE}, 1'b1,
                '{1'b1, 1'b1, LA_NEW, 6'd1, 8'h01, 48'h0, 1'b1, 1'b0, 1'b0, 32'd2});
        add_row('{1'b0, 3'd7, 48'h0, BCAST_MAC, ARP_TYPE}, 1'b1,
                '{1'b1, 1'b1, LA_NEW, 6'd2, 8'h80, BCAST_MAC, 1'b1, 1'b0, 1'b0, 32'd2});
        add_row('{1'b0, 3'd0, BCAST_MAC, 48'h0, ARP_TYPE}, 1'b0, '0);
        add_row('{1'b0, 3'd7, 48'h0, 48'h0, ARP_TYPE}, 1'b0, '0);
        add_row('{1'b0, 3'd5, OWN_MAC_RST, OWN_MAC_RST, ARP_TYPE}, 1'b0, '0);
        add_row('{1'b0, 3'd1, 48'h0000_0000_0001, 48'h0a0b_0c0d_0e0f, 16'h0805}, 1'b0, '0);
        add_row('{1'b0, 3'd2, 48'h8000_0000_0000, 48'h0a0b_0c0d_0e0f, 16'h0807}, 1'b0, '0);
        add_row('{1'b0, 3'd4, 48'h5555_5555_5555, 48'h0a0b_0c0d_0e0f, 16'h0608}, 1'b0, '0);
        add_row('{1'b0, 3'd6, 48'haaaa_aaaa_aaaa, 48'h0a0b_0c0d_0e0f, 16'hf7f9}, 1'b0, '0);
        add_row('{1'b1, 3'd2, OWN_MAC_RST, 48'h0102_0304_0506, ARP_TYPE}, 1'b1,
                '{1'b0, 1'b0, LA_NONE, 6'd0, 8'h00, 48'h0, 1'b0, 1'b0, 1'b0, 32'd4});
        add_row('{1'b0, 3'd7, OWN_MAC_RST ^ 48'h1, BCAST_MAC, ARP_TYPE}, 1'b0, '0);
        add_row('{1'b0, 3'd3, BCAST_MAC ^ 48'h8000_0000_0000, BCAST_MAC, ARP_TYPE},
                1'b0, '0);
        add_row('{1'b0, 3'd6, BCAST_MAC, 48'h0102_0304_0506, ARP_TYPE}, 1'b0, '0);

        // reset pulse
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        foreach (dir_rows[k])
            send_frame(dir_rows[k].frm, dir_rows[k].typed, dir_rows[k].want);

        // random part, one own_mac setting and one idling mix per phase
        for (int phase = 0; phase < 3; phase++)
        begin
            logic [63:0] r;
            r = {$urandom(), $urandom()};
            drain();
            case (phase)
                0: write_own_mac('0);
                1: write_own_mac(BCAST_MAC);
                default: write_own_mac(r[MAC_W-1:0]);
            endcase
            src_idle = (phase == 0) ? 15 : (phase == 1) ? 66 : 0;
            snk_idle = (phase == 0) ? 66 : (phase == 1) ? 15 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_frame(random_frame(), 1'b0, '0);
        end
        drain();

        $display("covered %0d frames and %0d verdicts, %0d entries learned",
                 frames_sent, verdicts_checked, used_entries - 1);
        $display("%0d table-full misses, %0d cpu frames, own_mac at reset, zero, ones, random",
                 full_seen, cpu_cnt);
        if (err_count == 0 && verdict_q.size() == 0)
            $display("mac_address_learning_table_unit test passed");
        else
            $display("mac_address_learning_table_unit test failed");
        $finish;
    end

endmodule
